FILE: hdl/pss_pkg.sv
// Shared constants, opcodes and controller/datapath command and status types.
package pss_pkg;

  localparam int SCREEN_SIZE_DEF   = 512;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int COORD_W  = 9;
  localparam int LEFT_O_W = 10;
  localparam int OP_W     = 2;

  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_ROW = 2'd2;

  typedef struct packed {
    logic latch;      // capture request fields
    logic setup;      // order endpoints, load walk registers
    logic div_start;  // launch slope division
    logic walk_en;    // visit one row
    logic clr_en;     // clear one table entry
    logic rd_issue;   // read requested row
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic horizontal;
    logic div_done;
    logic walk_last;
  } status_t;

endpackage

FILE: hdl/pss_div.sv
// Restoring divider, one quotient bit per cycle, for the edge slope.
module pss_div #(
  parameter int QW = 25
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [QW-1:0]              dividend_i,
  input  logic [pss_pkg::COORD_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [QW-1:0]              quotient_o
);

  localparam int CW = $clog2(QW + 1);
  localparam int DW = pss_pkg::COORD_W;

  logic [QW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvs_q;
  logic [CW-1:0] cnt_q;
  logic          run_q, done_q;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_q, quo_q[QW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    quo_d = {quo_q[QW-2:0], fits};
    rem_d = fits ? DW'(trial - {1'b0, dvs_q}) : DW'(trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(QW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hdl/pss_ctrl.sv
// Controller state machine: clear sweep, edge division and walk, row read.
module pss_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pss_pkg::OP_W-1:0]     opcode_i,
  input  pss_pkg::status_t             status_i,
  output pss_pkg::cmd_t                cmd_o,
  output logic                         busy_o,
  output logic                         result_valid_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_SETUP = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_READ  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          unique case (opcode_i)
            pss_pkg::OP_CLEAR:    state_d = S_CLEAR;
            pss_pkg::OP_ADD_EDGE: state_d = S_SETUP;
            pss_pkg::OP_READ_ROW: begin
              cmd_o.rd_issue = 1'b1;
              state_d        = S_READ;
            end
            default:              state_d = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        if (status_i.horizontal) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (status_i.div_done) state_d = S_WALK;
      end
      S_WALK: begin
        cmd_o.walk_en = 1'b1;
        if (status_i.walk_last) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_IDLE;
      S_READ:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o         = state_q != S_IDLE;
  assign result_valid_o = state_q == S_READ;

endmodule

FILE: hdl/pss_dp.sv
// Datapath: edge tables, walk accumulator, slope setup and span read-out.
module pss_dp #(
  parameter int SCREEN_SIZE   = pss_pkg::SCREEN_SIZE_DEF,
  parameter int FRACTION_BITS = pss_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pss_pkg::cmd_t                 cmd_i,
  output pss_pkg::status_t              status_o,
  input  logic [pss_pkg::COORD_W-1:0]   x_start_i,
  input  logic [pss_pkg::COORD_W-1:0]   y_start_i,
  input  logic [pss_pkg::COORD_W-1:0]   x_end_i,
  input  logic [pss_pkg::COORD_W-1:0]   y_end_i,
  input  logic [pss_pkg::COORD_W-1:0]   row_i,
  output logic [pss_pkg::COORD_W-1:0]   row_out_o,
  output logic [pss_pkg::LEFT_O_W-1:0]  left_x_o,
  output logic [pss_pkg::COORD_W-1:0]   right_x_o,
  output logic                          span_present_o
);

  localparam int CW = pss_pkg::COORD_W;
  localparam int AW = $clog2(SCREEN_SIZE);
  localparam int LW = ($clog2(SCREEN_SIZE) + 1 > pss_pkg::LEFT_O_W) ?
                      $clog2(SCREEN_SIZE) + 1 : pss_pkg::LEFT_O_W;
  localparam int QW = CW + FRACTION_BITS;
  localparam int WB = CW + 1 + FRACTION_BITS;
  localparam logic [31:0] SCREEN_W = 32'(SCREEN_SIZE);

  // request fields
  logic [CW-1:0] xs_q, ys_q, xe_q, ye_q, row_q;
  logic          rd_in_range_q;

  // ordered edge
  logic          swap, neg;
  logic [CW-1:0] lo_x, lo_y, hi_x, hi_y, dx_mag, dy;
  logic [QW-1:0] dividend, quotient;
  logic          div_done;

  // walk
  logic [WB-1:0] walk_x_q, step_q;
  logic [CW-1:0] walk_row_q, hi_y_q;
  logic [CW:0]   xi;
  logic          walk_in_range;

  // table update stage
  logic          upd_valid_q;
  logic [AW-1:0] upd_addr_q;
  logic [CW:0]   upd_xi_q;

  // clear sweep
  logic [AW-1:0] sweep_q;
  logic          sweep_last;

  // memories
  logic [LW-1:0] left_mem  [SCREEN_SIZE];
  logic [CW-1:0] right_mem [SCREEN_SIZE];
  logic [LW-1:0] left_rd_q, left_wd, left_out;
  logic [CW-1:0] right_rd_q, right_wd, right_out;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          mem_we, mem_re;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      xs_q          <= x_start_i;
      ys_q          <= y_start_i;
      xe_q          <= x_end_i;
      ye_q          <= y_end_i;
      row_q         <= row_i;
      rd_in_range_q <= 32'(row_i) < SCREEN_W;
    end
  end

  assign swap   = ys_q > ye_q;
  assign lo_x   = swap ? xe_q : xs_q;
  assign lo_y   = swap ? ye_q : ys_q;
  assign hi_x   = swap ? xs_q : xe_q;
  assign hi_y   = swap ? ys_q : ye_q;
  assign neg    = hi_x < lo_x;
  assign dx_mag = neg ? CW'(lo_x - hi_x) : CW'(hi_x - lo_x);
  assign dy     = CW'(hi_y - lo_y);
  assign dividend = {dx_mag, {FRACTION_BITS{1'b0}}};

  pss_div #(
    .QW(QW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (dy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign xi            = walk_x_q[WB-1 -: CW+1];
  assign walk_in_range = 32'(walk_row_q) < SCREEN_W;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_x_q    <= '0;
      walk_row_q  <= '0;
      upd_valid_q <= 1'b0;
      sweep_q     <= '0;
    end else begin
      if (cmd_i.setup) begin
        walk_x_q   <= {1'b0, lo_x, {FRACTION_BITS{1'b0}}};
        walk_row_q <= lo_y;
      end else if (cmd_i.walk_en) begin
        walk_x_q   <= walk_x_q + step_q;
        walk_row_q <= walk_row_q + CW'(1);
      end
      upd_valid_q <= cmd_i.walk_en && walk_in_range;
      if (cmd_i.clr_en) begin
        sweep_q <= sweep_last ? '0 : sweep_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      hi_y_q <= hi_y;
    end
    if (div_done) begin
      step_q <= neg ? WB'(0) - WB'(quotient) : WB'(quotient);
    end
    upd_addr_q <= AW'(walk_row_q);
    upd_xi_q   <= xi;
  end

  assign sweep_last = sweep_q == AW'(SCREEN_SIZE - 1);

  always_comb begin
    mem_we   = cmd_i.clr_en | upd_valid_q;
    wr_addr  = cmd_i.clr_en ? sweep_q : upd_addr_q;
    left_wd  = LW'(SCREEN_SIZE);
    right_wd = '0;
    if (!cmd_i.clr_en) begin
      left_wd  = (LW'(upd_xi_q) < left_rd_q) ? LW'(upd_xi_q) : left_rd_q;
      right_wd = (upd_xi_q > {1'b0, right_rd_q}) ? CW'(upd_xi_q) : right_rd_q;
    end
    mem_re  = cmd_i.rd_issue | cmd_i.walk_en;
    rd_addr = cmd_i.rd_issue ? AW'(row_i) : AW'(walk_row_q);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      left_mem[wr_addr]  <= left_wd;
      right_mem[wr_addr] <= right_wd;
    end
    if (mem_re) begin
      left_rd_q  <= left_mem[rd_addr];
      right_rd_q <= right_mem[rd_addr];
    end
  end

  assign left_out  = rd_in_range_q ? left_rd_q : LW'(SCREEN_SIZE);
  assign right_out = rd_in_range_q ? right_rd_q : '0;

  assign row_out_o      = row_q;
  assign left_x_o       = pss_pkg::LEFT_O_W'(left_out);
  assign right_x_o      = right_out;
  assign span_present_o = left_out < LW'(right_out);

  assign status_o.clr_last   = sweep_last;
  assign status_o.horizontal = ys_q == ye_q;
  assign status_o.div_done   = div_done;
  assign status_o.walk_last  = walk_row_q == CW'(hi_y_q - CW'(1));

endmodule

FILE: hdl/polygon_scanline_span_table_top.sv
// Top level of the scanline polygon span table: controller plus datapath.
// Clear: busy while every table entry is written, one table entry written per cycle.
// Add edge: setup, serial slope division, one row per cycle
// (read/modify/write overlapped across rows), then a drain state; a flat edge ends after setup.
// Read row: result strobe in the cycle after the request is taken; receiver cannot stall.
// After reset the tables are swept to their empty values, busy high.
module polygon_scanline_span_table_top #(
  parameter int SCREEN_SIZE   = pss_pkg::SCREEN_SIZE_DEF,
  parameter int FRACTION_BITS = pss_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [pss_pkg::OP_W-1:0]      opcode_i,
  input  logic [pss_pkg::COORD_W-1:0]   x_start_i,
  input  logic [pss_pkg::COORD_W-1:0]   y_start_i,
  input  logic [pss_pkg::COORD_W-1:0]   x_end_i,
  input  logic [pss_pkg::COORD_W-1:0]   y_end_i,
  input  logic [pss_pkg::COORD_W-1:0]   row_i,
  output logic                          result_valid_o,
  output logic [pss_pkg::COORD_W-1:0]   row_out_o,
  output logic [pss_pkg::LEFT_O_W-1:0]  left_x_o,
  output logic [pss_pkg::COORD_W-1:0]   right_x_o,
  output logic                          span_present_o
);

  pss_pkg::cmd_t    cmd;
  pss_pkg::status_t status;

  pss_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .opcode_i       (opcode_i),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o)
  );

  pss_dp #(
    .SCREEN_SIZE   (SCREEN_SIZE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .x_start_i      (x_start_i),
    .y_start_i      (y_start_i),
    .x_end_i        (x_end_i),
    .y_end_i        (y_end_i),
    .row_i          (row_i),
    .row_out_o      (row_out_o),
    .left_x_o       (left_x_o),
    .right_x_o      (right_x_o),
    .span_present_o (span_present_o)
  );

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the scanline polygon span table: directed and random requests.
`timescale 1ns / 1ps

module tb;

  localparam int SCREEN = pss_pkg::SCREEN_SIZE_DEF;
  localparam int TAW = $clog2(SCREEN);
  localparam int FRAC = pss_pkg::FRACTION_BITS_DEF;
  localparam logic [63:0] WALK_MASK = (64'd1 << (10 + FRAC)) - 64'd1;
  localparam logic [pss_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_GOAL = 800;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 600;

  typedef struct packed {
    logic [pss_pkg::COORD_W-1:0] row;
    logic [pss_pkg::LEFT_O_W-1:0] left;
    logic [pss_pkg::COORD_W-1:0] right;
    logic present;
  } span_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic [pss_pkg::OP_W-1:0] opcode_i;
  logic [pss_pkg::COORD_W-1:0] x_start_i, y_start_i, x_end_i, y_end_i, row_i;
  logic result_valid_o;
  logic [pss_pkg::COORD_W-1:0] row_out_o;
  logic [pss_pkg::LEFT_O_W-1:0] left_x_o;
  logic [pss_pkg::COORD_W-1:0] right_x_o;
  logic span_present_o;

  logic [pss_pkg::LEFT_O_W-1:0] left_tbl [0:SCREEN-1];
  logic [pss_pkg::COORD_W-1:0] right_tbl [0:SCREEN-1];
  span_t span_expected [$];
  int errors = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  polygon_scanline_span_table_top u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .opcode_i(opcode_i),
    .x_start_i(x_start_i),
    .y_start_i(y_start_i),
    .x_end_i(x_end_i),
    .y_end_i(y_end_i),
    .row_i(row_i),
    .result_valid_o(result_valid_o),
    .row_out_o(row_out_o),
    .left_x_o(left_x_o),
    .right_x_o(right_x_o),
    .span_present_o(span_present_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void table_clear();
    for (int i = 0; i < SCREEN; i++) begin
      left_tbl[TAW'(i)] = pss_pkg::LEFT_O_W'(SCREEN);
      right_tbl[TAW'(i)] = '0;
    end
  endfunction

  function automatic void table_add_edge(input logic [pss_pkg::COORD_W-1:0] xa, ya, xb, yb);
    logic [pss_pkg::COORD_W-1:0] lo_x, lo_y, hi_x, hi_y;
    logic [63:0] pos, slope, mag;
    logic [pss_pkg::LEFT_O_W-1:0] xi;
    lo_x = xa; lo_y = ya; hi_x = xb; hi_y = yb;
    if (ya > yb) begin
      lo_x = xb; lo_y = yb; hi_x = xa; hi_y = ya;
    end
    pos = 64'(lo_x) << FRAC;
    slope = '0;
    if (hi_y > lo_y) begin
      mag = 64'(hi_x < lo_x ? lo_x - hi_x : hi_x - lo_x) << FRAC;
      slope = mag / 64'(hi_y - lo_y);
      if (hi_x < lo_x) slope = -slope;
    end
    for (int r = int'(lo_y); r < int'(hi_y); r++) begin
      xi = pss_pkg::LEFT_O_W'((pos & WALK_MASK) >> FRAC);
      if (r < SCREEN) begin
        if (xi < left_tbl[TAW'(r)]) left_tbl[TAW'(r)] = xi;
        if (xi > pss_pkg::LEFT_O_W'(right_tbl[TAW'(r)]))
          right_tbl[TAW'(r)] = pss_pkg::COORD_W'(xi);
      end
      pos = pos + slope;
    end
  endfunction

  function automatic void predict_request(input logic [pss_pkg::OP_W-1:0] op,
                                          input logic [pss_pkg::COORD_W-1:0] xs, ys, xe, ye,
                                          rw);
    span_t s;
    case (op)
      pss_pkg::OP_CLEAR: table_clear();
      pss_pkg::OP_ADD_EDGE: table_add_edge(xs, ys, xe, ye);
      pss_pkg::OP_READ_ROW: begin
        s.row = rw;
        s.left = (rw < SCREEN) ? left_tbl[rw] : pss_pkg::LEFT_O_W'(SCREEN);
        s.right = (rw < SCREEN) ? right_tbl[rw] : '0;
        s.present = (s.left < pss_pkg::LEFT_O_W'(s.right));
        span_expected.push_back(s);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string field, input int unsigned exp_v, act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
      errors++;
    end
  endfunction

  task automatic send_request(input logic [pss_pkg::OP_W-1:0] op,
                              input logic [pss_pkg::COORD_W-1:0] xs, ys, xe, ye, rw);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    @(negedge clk_i);
    if (gap != 0) begin
      start_i <= 1'b0;
      opcode_i <= pss_pkg::OP_W'($urandom);
      x_start_i <= pss_pkg::COORD_W'($urandom);
      y_start_i <= pss_pkg::COORD_W'($urandom);
      x_end_i <= pss_pkg::COORD_W'($urandom);
      y_end_i <= pss_pkg::COORD_W'($urandom);
      row_i <= pss_pkg::COORD_W'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    opcode_i <= op;
    x_start_i <= xs;
    y_start_i <= ys;
    x_end_i <= xe;
    y_end_i <= ye;
    row_i <= rw;
    do @(posedge clk_i); while (busy_o);
    predict_request(op, xs, ys, xe, ye, rw);
    items_sent++;
  endtask

  task automatic read_row(input logic [pss_pkg::COORD_W-1:0] rw);
    send_request(pss_pkg::OP_READ_ROW, pss_pkg::COORD_W'($urandom), pss_pkg::COORD_W'($urandom),
                 pss_pkg::COORD_W'($urandom), pss_pkg::COORD_W'($urandom), rw);
  endtask

  task automatic add_edge(input logic [pss_pkg::COORD_W-1:0] xs, ys, xe, ye);
    send_request(pss_pkg::OP_ADD_EDGE, xs, ys, xe, ye, pss_pkg::COORD_W'($urandom));
  endtask

  task automatic test_reset_state();
    read_row(9'd0);
    read_row(9'd511);
  endtask

  task automatic test_edge_walk();
    add_edge(9'd0, 9'd0, 9'd511, 9'd511);
    read_row(9'd0);
    read_row(9'd255);
    read_row(9'd510);
    read_row(9'd511);
    // endpoints given bottom row first, x falling
    add_edge(9'd511, 9'd400, 9'd0, 9'd20);
    read_row(9'd20);
    read_row(9'd399);
  endtask

  task automatic test_special_edges();
    // flat edge visits no row
    add_edge(9'd3, 9'd100, 9'd500, 9'd100);
    read_row(9'd100);
    // one row, full width run
    add_edge(9'd0, 9'd450, 9'd511, 9'd451);
    read_row(9'd450);
    add_edge(9'd300, 9'd0, 9'd300, 9'd511);
    read_row(9'd0);
  endtask

  task automatic test_ignored_opcode();
    send_request(OP_UNUSED, 9'h1ff, 9'h000, 9'h1ff, 9'h1ff, 9'd100);
    read_row(9'd100);
  endtask

  task automatic test_clear();
    send_request(pss_pkg::OP_CLEAR, 9'h1ff, 9'h1ff, 9'h1ff, 9'h1ff, 9'h1ff);
    read_row(9'd0);
    read_row(9'd300);
  endtask

  task automatic test_random_polygons(input int item_goal);
    logic [pss_pkg::COORD_W-1:0] vx [0:5];
    logic [pss_pkg::COORD_W-1:0] vy [0:5];
    int n, height, base, ymin, ymax, reads;
    while (items_sent < item_goal) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) begin
        // stray request, any opcode
        send_request(pss_pkg::OP_W'($urandom_range(0, 3)), pss_pkg::COORD_W'($urandom),
                     pss_pkg::COORD_W'($urandom), pss_pkg::COORD_W'($urandom),
                     pss_pkg::COORD_W'($urandom), pss_pkg::COORD_W'($urandom));
      end else begin
        if ($urandom_range(0, 2) == 0)
          send_request(pss_pkg::OP_CLEAR, pss_pkg::COORD_W'($urandom),
                       pss_pkg::COORD_W'($urandom), pss_pkg::COORD_W'($urandom),
                       pss_pkg::COORD_W'($urandom), pss_pkg::COORD_W'($urandom));
        n = $urandom_range(3, 6);
        height = ($urandom_range(0, 9) == 0) ? 511 : $urandom_range(0, 40);
        base = $urandom_range(0, 511 - height);
        ymin = 511;
        ymax = 0;
        for (int k = 0; k < n; k++) begin
          vx[3'(k)] = pss_pkg::COORD_W'($urandom);
          vy[3'(k)] = pss_pkg::COORD_W'(base + $urandom_range(0, height));
          if (int'(vy[3'(k)]) < ymin) ymin = int'(vy[3'(k)]);
          if (int'(vy[3'(k)]) > ymax) ymax = int'(vy[3'(k)]);
        end
        for (int k = 0; k < n; k++)
          add_edge(vx[3'(k)], vy[3'(k)], vx[3'((k + 1) % n)], vy[3'((k + 1) % n)]);
        reads = $urandom_range(3, 8);
        for (int k = 0; k < reads; k++)
          read_row(($urandom_range(0, 4) == 0) ? pss_pkg::COORD_W'($urandom)
                                               : pss_pkg::COORD_W'($urandom_range(ymin, ymax)));
      end
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk_i) begin : result_check
    span_t exp_span;
    if (rst_ni && result_valid_o) begin
      if (span_expected.size() == 0) begin
        $display("%0t: unexpected result, row %0d left %0d right %0d present %0d",
                 $time, row_out_o, left_x_o, right_x_o, span_present_o);
        errors++;
      end else begin
        exp_span = span_expected.pop_front();
        check_field("row_out", 32'(exp_span.row), 32'(row_out_o));
        check_field("left_x", 32'(exp_span.left), 32'(left_x_o));
        check_field("right_x", 32'(exp_span.right), 32'(right_x_o));
        check_field("span_present", 32'(exp_span.present), 32'(span_present_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no request or result for %0d cycles", $time, idle_cycles);
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    opcode_i = pss_pkg::OP_CLEAR;
    x_start_i = '0;
    y_start_i = '0;
    x_end_i = '0;
    y_end_i = '0;
    row_i = '0;
    table_clear();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_edge_walk();
    test_special_edges();
    test_ignored_opcode();
    test_clear();
    test_random_polygons(ITEM_GOAL);

    @(negedge clk_i);
    start_i <= 1'b0;
    while (span_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/pss_pkg.sv
hdl/pss_div.sv
hdl/pss_ctrl.sv
hdl/pss_dp.sv
hdl/polygon_scanline_span_table_top.sv
verif/tb.sv
